### design/ordered_list_search_remove_assert.svh
// ----------------------------------------------------------------------------
// Ordered list search and remove: assertion macros
// Shorthand for the concurrent checks at the end of the top level. The macros
// sample on clk and are disabled while rst is high.
// ----------------------------------------------------------------------------
`ifndef ORDERED_LIST_SEARCH_REMOVE_ASSERT_SVH
`define ORDERED_LIST_SEARCH_REMOVE_ASSERT_SVH

// Same-cycle implication.
`define OLSR_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication.
`define OLSR_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

### design/olsr_pkg.sv
// ----------------------------------------------------------------------------
// olsr_pkg
// Sizes, operation codes and status codes shared by the ordered list files.
// ----------------------------------------------------------------------------
package olsr_pkg;

  // List capacity and entry width.
  localparam int DEPTH     = 64;
  localparam int KEY_WIDTH = 32;
  localparam int ADDR_W    = $clog2(DEPTH);
  localparam int CNT_W     = $clog2(DEPTH + 1);

  // Field widths of the request and response words.
  localparam int OP_W     = 2;
  localparam int STATUS_W = 2;

  typedef logic [OP_W-1:0]      op_t;
  typedef logic [STATUS_W-1:0]  status_t;
  typedef logic [KEY_WIDTH-1:0] key_t;
  typedef logic [ADDR_W-1:0]    addr_t;
  typedef logic [CNT_W-1:0]     cnt_t;

  // Operation codes.
  localparam op_t OP_APPEND = 2'd0;
  localparam op_t OP_READ   = 2'd1;
  localparam op_t OP_FIND   = 2'd2;
  localparam op_t OP_REMOVE = 2'd3;

  // Status codes.
  localparam status_t ST_OK        = 2'd0;
  localparam status_t ST_FULL      = 2'd1;
  localparam status_t ST_NOT_FOUND = 2'd2;
  localparam status_t ST_RANGE     = 2'd3;

endpackage

### design/olsr_req_if.sv
// ----------------------------------------------------------------------------
// olsr_req_if
// Request channel: one word holds an operation, a key and a position.
// ----------------------------------------------------------------------------
interface olsr_req_if;
  import olsr_pkg::*;

  logic  valid;
  logic  ready;
  op_t   operation;
  key_t  key_value;
  cnt_t  position;

  modport source (output valid, output operation, output key_value, output position,
                  input ready);
  modport sink   (input valid, input operation, input key_value, input position,
                  output ready);
endinterface

### design/olsr_rsp_if.sv
// ----------------------------------------------------------------------------
// olsr_rsp_if
// Response channel: one word per request with status, index, data and count.
// ----------------------------------------------------------------------------
interface olsr_rsp_if;
  import olsr_pkg::*;

  logic    valid;
  logic    ready;
  status_t status;
  addr_t   found_index;
  key_t    read_value;
  cnt_t    entry_count;

  modport source (output valid, output status, output found_index, output read_value,
                  output entry_count, input ready);
  modport sink   (input valid, input status, input found_index, input read_value,
                  input entry_count, output ready);
endinterface

### design/ordered_list_search_remove.sv
// ----------------------------------------------------------------------------
// ordered_list_search_remove
// A bounded list of key words kept in insertion order, with append, read,
// find-first and remove-first operations, one response word per request.
// ----------------------------------------------------------------------------
// The list lives in a single-port-write, single-port-read RAM, and one
// comparator walks it under a small sequencer, one RAM access per step. A
// request is taken only while the sequencer is idle; the response sits in an
// output register, so the next request may enter while it waits. Append
// writes the key at the end of the list; read fetches one entry through the
// registered read port. A read past the count or an append to a full list
// skips the RAM and returns its status. Find fetches and compares one entry
// at a time from the request's position until a match or the end of the
// list; remove then moves each later entry one place down, read then write,
// and lowers the count. An unread response holds the next one in S_DONE.
// ----------------------------------------------------------------------------
module ordered_list_search_remove (
  input logic  clk,
  input logic  rst,
  olsr_req_if.sink   req,
  olsr_rsp_if.source rsp
);
  import olsr_pkg::*;

  // Sequencer states.
  localparam logic [2:0] S_IDLE   = 3'd0;
  localparam logic [2:0] S_RDWAIT = 3'd1;
  localparam logic [2:0] S_SCAN   = 3'd2;
  localparam logic [2:0] S_CMP    = 3'd3;
  localparam logic [2:0] S_SHRD   = 3'd4;
  localparam logic [2:0] S_SHWR   = 3'd5;
  localparam logic [2:0] S_DONE   = 3'd6;

  logic [2:0] state;
  logic [2:0] state_next;
  cnt_t       count;
  cnt_t       count_next;

  // Working registers for the request in flight.
  op_t     cur_op;
  key_t    cur_key;
  cnt_t    idx;
  cnt_t    idx_next;
  status_t res_status;
  status_t res_status_next;
  addr_t   res_found;
  addr_t   res_found_next;
  key_t    res_value;
  key_t    res_value_next;

  // Output register.
  logic    out_valid;
  status_t out_status;
  addr_t   out_found;
  key_t    out_value;
  cnt_t    out_count;

  // RAM ports.
  logic  ram_we;
  addr_t ram_waddr;
  key_t  ram_wdata;
  addr_t ram_raddr;
  key_t  ram_rdata;

  logic accept;
  logic out_free;

  assign req.ready = (state == S_IDLE);
  assign accept    = req.valid && req.ready;
  assign out_free  = !out_valid || rsp.ready;

  olsr_ram #(
    .WIDTH (KEY_WIDTH),
    .DEPTH (DEPTH)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  // Sequencer: dispatch, scan, compare and shift steps.
  always_comb begin
    state_next      = state;
    count_next      = count;
    idx_next        = idx;
    res_status_next = res_status;
    res_found_next  = res_found;
    res_value_next  = res_value;
    ram_we          = 1'b0;
    ram_waddr       = idx[ADDR_W-1:0];
    ram_wdata       = ram_rdata;
    ram_raddr       = idx[ADDR_W-1:0];

    case (state)
      S_IDLE: begin
        if (accept) begin
          res_status_next = ST_OK;
          res_found_next  = '0;
          res_value_next  = '0;
          idx_next        = req.position;
          case (req.operation)
            OP_APPEND: begin
              if (count == CNT_W'(DEPTH)) begin
                res_status_next = ST_FULL;
              end else begin
                ram_we     = 1'b1;
                ram_waddr  = count[ADDR_W-1:0];
                ram_wdata  = req.key_value;
                count_next = count + CNT_W'(1);
              end
              state_next = S_DONE;
            end
            OP_READ: begin
              if (req.position >= count) begin
                res_status_next = ST_RANGE;
                state_next      = S_DONE;
              end else begin
                ram_raddr  = req.position[ADDR_W-1:0];
                state_next = S_RDWAIT;
              end
            end
            default: begin
              state_next = S_SCAN;
            end
          endcase
        end
      end

      S_RDWAIT: begin
        res_value_next = ram_rdata;
        state_next     = S_DONE;
      end

      // Fetch the entry at idx, or stop at the end of the list.
      S_SCAN: begin
        if (idx >= count) begin
          res_status_next = ST_NOT_FOUND;
          state_next      = S_DONE;
        end else begin
          state_next = S_CMP;
        end
      end

      // Compare the fetched entry with the key.
      S_CMP: begin
        if (ram_rdata == cur_key) begin
          res_found_next = idx[ADDR_W-1:0];
          state_next     = (cur_op == OP_REMOVE) ? S_SHRD : S_DONE;
        end else begin
          idx_next   = idx + CNT_W'(1);
          state_next = S_SCAN;
        end
      end

      // Read the entry above idx, or finish the removal.
      S_SHRD: begin
        if ((idx + CNT_W'(1)) >= count) begin
          count_next = count - CNT_W'(1);
          state_next = S_DONE;
        end else begin
          ram_raddr  = ADDR_W'(idx + CNT_W'(1));
          state_next = S_SHWR;
        end
      end

      // Move that entry down into idx.
      S_SHWR: begin
        ram_we     = 1'b1;
        idx_next   = idx + CNT_W'(1);
        state_next = S_SHRD;
      end

      S_DONE: begin
        if (out_free) begin
          state_next = S_IDLE;
        end
      end

      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  // Control registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      count     <= '0;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      count <= count_next;
      if (state == S_DONE && out_free) begin
        out_valid <= 1'b1;
      end else if (rsp.ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    if (accept) begin
      cur_op  <= req.operation;
      cur_key <= req.key_value;
    end
    idx        <= idx_next;
    res_status <= res_status_next;
    res_found  <= res_found_next;
    res_value  <= res_value_next;
    if (state == S_DONE && out_free) begin
      out_status <= res_status;
      out_found  <= res_found;
      out_value  <= res_value;
      out_count  <= count;
    end
  end

  assign rsp.valid       = out_valid;
  assign rsp.status      = out_status;
  assign rsp.found_index = out_found;
  assign rsp.read_value  = out_value;
  assign rsp.entry_count = out_count;

  // Checks on the sequencer and the count.
`include "ordered_list_search_remove_assert.svh"

  `OLSR_ASSERT_NOW(a_count_bound, 1'b1, count <= CNT_W'(DEPTH), "entry count past capacity")
  `OLSR_ASSERT_NEXT(a_busy_after_accept, accept, !req.ready, "request taken while busy")
  `OLSR_ASSERT_NOW(a_full_status, rsp.valid && rsp.status == ST_FULL, rsp.entry_count == CNT_W'(DEPTH), "full status below capacity")

endmodule

### design/olsr_ram.sv
// ----------------------------------------------------------------------------
// olsr_ram
// Generic single-write, single-read RAM with a registered read port.
// ----------------------------------------------------------------------------
module olsr_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port and registered read port.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule
